// File: rtl/core/lsfa_pkg.sv
// ----------------------------------------------------------------------------
// lsfa_pkg: shared definitions for the log spectrum frame averager
// Field widths, register codes, the log2 table, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsfa_pkg;

   localparam int DEF_BIN_COUNT  = 256;
   localparam int DEF_MAX_FRAMES = 16;

   localparam int AMP_W      = 16;
   localparam int BIN_IDX_W  = 8;
   localparam int LEVEL_W    = 16;
   localparam int GAIN_W     = 9;
   localparam int FLOOR_W    = 13;
   localparam int AVG_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(50);
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(328);
   localparam logic [AVG_W-1:0]   AVG_RESET   = AVG_W'(9);

   localparam int Y_W        = AMP_W + GAIN_W + 1;
   localparam int EXP_W      = 4;
   localparam int FRAC_W     = 16;
   localparam int TAB_W      = 17;
   localparam int TAB_IDX_W  = 5;
   localparam int R_W        = 12;
   localparam int DIFF_W     = 13;
   localparam int IPROD_W    = DIFF_W + R_W;
   localparam int L2_W       = 21;
   localparam int LOG10_2_Q16 = 19728;
   localparam int LV_PROD_W  = 36;
   localparam int LV_SHIFT   = 18;
   localparam int LV_W       = LV_PROD_W - LV_SHIFT;

   localparam int DIV_BITS_PER_STEP = 2;
   localparam int DIV_STEPS         = LEVEL_W / DIV_BITS_PER_STEP;
   localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_FACTOR   = 2'd0,
      CSR_NOISE_FLOOR   = 2'd1,
      CSR_AVERAGE_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_NORM,
      ST_INTERP,
      ST_LEVEL,
      ST_STORE,
      ST_SUM,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic scale;
      logic norm;
      logic interp;
      logic level;
      logic store;
      logic sum_issue;
      logic div_start;
      logic div_step;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic norm_done;
      logic issue_last;
      logic div_last;
      logic rsp_busy;
   } dp_status_type;

   // round(65536 * log2(1 + k/16))
   function automatic logic [TAB_W-1:0] log2_tab(input logic [TAB_IDX_W-1:0] idx);
      logic [TAB_W-1:0] v;
      case (idx)
         5'd0:    v = 17'd0;
         5'd1:    v = 17'd5732;
         5'd2:    v = 17'd11136;
         5'd3:    v = 17'd16248;
         5'd4:    v = 17'd21098;
         5'd5:    v = 17'd25711;
         5'd6:    v = 17'd30109;
         5'd7:    v = 17'd34313;
         5'd8:    v = 17'd38336;
         5'd9:    v = 17'd42196;
         5'd10:   v = 17'd45904;
         5'd11:   v = 17'd49472;
         5'd12:   v = 17'd52911;
         5'd13:   v = 17'd56228;
         5'd14:   v = 17'd59434;
         5'd15:   v = 17'd62534;
         5'd16:   v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/lsfa_ram.sv
// ----------------------------------------------------------------------------
// lsfa_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lsfa_datapath.sv
// ----------------------------------------------------------------------------
// lsfa_datapath: log level arithmetic, level store and averaging divider
// Holds the configuration registers, slot pointer, log10(1+x) pipeline,
// the level store RAM, the slot accumulator and the result register.
// ----------------------------------------------------------------------------
module lsfa_datapath
   import lsfa_pkg::*;
#(
   parameter int BIN_COUNT  = DEF_BIN_COUNT,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [AMP_W-1:0]      req_amplitude,
   input  logic [BIN_IDX_W-1:0]  req_bin_index,
   input  logic                  req_frame_start,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [LEVEL_W-1:0]    rsp_averaged_level,
   output logic [BIN_IDX_W-1:0]  rsp_out_bin_index
);

   localparam int DEPTH   = MAX_FRAMES * BIN_COUNT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int BIN_W   = $clog2(BIN_COUNT);
   localparam int SLOT_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int REM_W   = CNT_W + 1;
   localparam int ACC_W   = LEVEL_W + $clog2(MAX_FRAMES);
   localparam int CMP_W   = 8;
   localparam int MOD_W   = FLOOR_W + BIN_IDX_W;
   localparam logic [ADDR_W-1:0] BIN_STRIDE = ADDR_W'(BIN_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

   function automatic logic [BIN_W-1:0] fold_bin(input logic [BIN_IDX_W-1:0] raw);
      logic [MOD_W-1:0] r;
      r = MOD_W'(raw);
      for (int k = BIN_IDX_W - 1; k >= 0; k--) begin
         if (r >= (MOD_W'(BIN_COUNT) << k)) begin
            r = r - (MOD_W'(BIN_COUNT) << k);
         end
      end
      return BIN_W'(r);
   endfunction

   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [FLOOR_W-1:0]   floor_ff, floor_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic [SLOT_W-1:0]    ptr_ff, ptr_in;
   logic [AMP_W-1:0]     amp_ff;
   logic [BIN_IDX_W-1:0] raw_bin_ff;
   logic [BIN_W-1:0]     bin_ff;
   logic [Y_W-1:0]       y_ff, y_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic [TAB_W-1:0]     t0_ff;
   logic [DIFF_W-1:0]    interp_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [ADDR_W-1:0]    clear_ff;
   logic [ADDR_W-1:0]    rd_addr_ff;
   logic [CNT_W-1:0]     k_ff;
   logic                 rd_pending_ff;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [LEVEL_W-1:0]   nq_ff, nq_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic [BIN_IDX_W-1:0] rsp_bin_ff;

   logic [CMP_W-1:0]     avg_wide;
   logic [CMP_W-1:0]     n_wide;
   logic [CNT_W-1:0]     n_cnt;
   logic [CMP_W-1:0]     ptr_next_wide;
   logic [AMP_W-1:0]     diff_amp;
   logic [FRAC_W-1:0]    frac_bits;
   logic [TAB_W-1:0]     t0, t1;
   logic [IPROD_W-1:0]   iprod;
   logic [TAB_W-1:0]     frac_sum;
   logic [L2_W-1:0]      l2;
   logic [LV_PROD_W-1:0] lv_prod;
   logic [LV_W-1:0]      lv;
   logic [LEVEL_W-1:0]   level_in;
   logic [ADDR_W-1:0]    wr_addr;
   logic [LEVEL_W-1:0]   wr_data;
   logic                 wr_en;
   logic [LEVEL_W-1:0]   rd_data;
   logic [REM_W-1:0]     n_rem;

   // effective slot count
   always_comb begin
      avg_wide = CMP_W'(avg_ff);
      if (avg_wide == '0) begin
         n_wide = CMP_W'(1);
      end else if (avg_wide > CMP_W'(MAX_FRAMES)) begin
         n_wide = CMP_W'(MAX_FRAMES);
      end else begin
         n_wide = avg_wide;
      end
      n_cnt = CNT_W'(n_wide);
      n_rem = REM_W'(n_wide);
   end

   always_comb begin
      gain_in  = gain_ff;
      floor_in = floor_ff;
      avg_in   = avg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_FACTOR:   gain_in  = csr_wdata[GAIN_W-1:0];
            CSR_NOISE_FLOOR:   floor_in = csr_wdata[FLOOR_W-1:0];
            CSR_AVERAGE_COUNT: avg_in   = csr_wdata[AVG_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the ring slot on frame start
   always_comb begin
      ptr_next_wide = CMP_W'(ptr_ff) + CMP_W'(1);
      ptr_in = ptr_ff;
      if (cmd.accept && req_frame_start) begin
         ptr_in = (ptr_next_wide >= n_wide) ? '0 : SLOT_W'(ptr_next_wide);
      end
   end

   // scale and normalize
   always_comb begin
      diff_amp = (amp_ff > AMP_W'(floor_ff)) ? (amp_ff - AMP_W'(floor_ff)) : '0;
      y_in   = y_ff;
      exp_in = exp_ff;
      if (cmd.scale) begin
         y_in   = Y_W'(1 << FRAC_W) + Y_W'(diff_amp) * Y_W'(gain_ff);
         exp_in = EXP_W'(Y_W - 1 - FRAC_W);
      end else if (cmd.norm) begin
         y_in   = {y_ff[Y_W-2:0], 1'b0};
         exp_in = exp_ff - EXP_W'(1);
      end
   end

   // table interpolation and log10 scaling
   always_comb begin
      frac_bits = y_ff[Y_W-2 -: FRAC_W];
      t0        = log2_tab(TAB_IDX_W'(frac_bits[FRAC_W-1 -: 4]));
      t1        = log2_tab(TAB_IDX_W'(frac_bits[FRAC_W-1 -: 4]) + TAB_IDX_W'(1));
      iprod     = IPROD_W'(DIFF_W'(t1 - t0)) * IPROD_W'(frac_bits[R_W-1:0]);
      frac_sum  = t0_ff + TAB_W'(interp_ff);
      l2        = L2_W'({exp_ff, {FRAC_W{1'b0}}}) + L2_W'(frac_sum);
      lv_prod   = LV_PROD_W'(l2) * LV_PROD_W'(LOG10_2_Q16)
                  + (LV_PROD_W'(1) << (LV_SHIFT - 1));
      lv        = lv_prod[LV_PROD_W-1:LV_SHIFT];
      level_in  = (lv > LV_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} : lv[LEVEL_W-1:0];
   end

   // level store
   always_comb begin
      wr_en   = cmd.clear_wr || cmd.store;
      wr_addr = cmd.clear_wr ? clear_ff
                             : (ADDR_W'(ptr_ff) * BIN_STRIDE + ADDR_W'(bin_ff));
      wr_data = cmd.clear_wr ? '0 : level_ff;
   end

   lsfa_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.sum_issue),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      acc_in = acc_ff;
      if (cmd.store) begin
         acc_in = '0;
      end else if (rd_pending_ff) begin
         acc_in = acc_ff + ACC_W'(rd_data);
      end
   end

   // restoring divide of the slot sum by the count
   always_comb begin
      rem_in = rem_ff;
      nq_in  = nq_ff;
      if (cmd.div_start) begin
         rem_in = REM_W'(acc_ff >> LEVEL_W);
         nq_in  = acc_ff[LEVEL_W-1:0];
      end else if (cmd.div_step) begin
         for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            rem_in = {rem_in[REM_W-2:0], nq_in[LEVEL_W-1]};
            nq_in  = {nq_in[LEVEL_W-2:0], rem_in >= n_rem};
            if (rem_in >= n_rem) begin
               rem_in = rem_in - n_rem;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         floor_ff      <= FLOOR_RESET;
         avg_ff        <= AVG_RESET;
         ptr_ff        <= '0;
         clear_ff      <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gain_ff       <= gain_in;
         floor_ff      <= floor_in;
         avg_ff        <= avg_in;
         ptr_ff        <= ptr_in;
         rd_pending_ff <= cmd.sum_issue;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.clear_wr) begin
            clear_ff <= clear_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      exp_ff <= exp_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      if (cmd.accept) begin
         amp_ff     <= req_amplitude;
         raw_bin_ff <= req_bin_index;
         bin_ff     <= fold_bin(req_bin_index);
      end
      if (cmd.interp) begin
         t0_ff     <= t0;
         interp_ff <= iprod[IPROD_W-1:R_W];
      end
      if (cmd.level) begin
         level_ff <= level_in;
      end
      if (cmd.store) begin
         rd_addr_ff <= ADDR_W'(bin_ff);
         k_ff       <= '0;
      end else if (cmd.sum_issue) begin
         rd_addr_ff <= rd_addr_ff + BIN_STRIDE;
         k_ff       <= k_ff + CNT_W'(1);
      end
      if (cmd.div_start) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.publish) begin
         rsp_level_ff <= nq_ff;
         rsp_bin_ff   <= raw_bin_ff;
      end
   end

   always_comb begin
      status.clear_last = (clear_ff == LAST_ADDR);
      status.norm_done  = y_ff[Y_W-1];
      status.issue_last = (k_ff == n_cnt - CNT_W'(1));
      status.div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
      status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_averaged_level = rsp_level_ff;
   assign rsp_out_bin_index  = rsp_bin_ff;

endmodule

// File: rtl/core/lsfa_controller.sv
// ----------------------------------------------------------------------------
// lsfa_controller: sequencer for the frame averager
// Runs the clearing pass, then steps each item through scale, normalize,
// interpolate, level, store, slot sum and divide.
// ----------------------------------------------------------------------------
module lsfa_controller
   import lsfa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_NORM;
         ST_NORM:     if (status.norm_done) state_in = ST_INTERP;
         ST_INTERP:   state_in = ST_LEVEL;
         ST_LEVEL:    state_in = ST_STORE;
         ST_STORE:    state_in = ST_SUM;
         ST_SUM:      if (status.issue_last) state_in = ST_DRAIN;
         ST_DRAIN:    state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:      if (status.div_last) state_in = ST_DONE;
         ST_DONE:     if (!status.rsp_busy) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:    cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SCALE:    cmd.scale = 1'b1;
         ST_NORM:     cmd.norm = !status.norm_done;
         ST_INTERP:   cmd.interp = 1'b1;
         ST_LEVEL:    cmd.level = 1'b1;
         ST_STORE:    cmd.store = 1'b1;
         ST_SUM:      cmd.sum_issue = 1'b1;
         ST_DRAIN:    ;
         ST_DIV_INIT: cmd.div_start = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_DONE:     cmd.publish = !status.rsp_busy;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/log_spectrum_frame_averager_unit.sv
// ----------------------------------------------------------------------------
// log_spectrum_frame_averager_unit: per-bin log level moving average
// Takes one spectral bin amplitude per item, turns it into log10(1+x) in Q2.14
// after noise floor removal and gain, writes it into the current ring slot of
// the bin and returns the mean of the bin over the active slots.
// ----------------------------------------------------------------------------
// After reset the level store is cleared one entry per cycle, all MAX_FRAMES *
// BIN_COUNT entries (4096 with the defaults), and req_ready stays low for that
// time; configuration writes are taken throughout. One item is in work at a
// time, and a new result is held back while an earlier result still waits
// unread. The work on an item runs through the normalize loop (one bit a cycle),
// the slot sum (one RAM read a cycle) and the divider (two quotient bits a
// cycle). A finished result waits in an output register, so the next item is
// taken while it is unread.
module log_spectrum_frame_averager_unit
   import lsfa_pkg::*;
#(
   parameter int BIN_COUNT  = DEF_BIN_COUNT,
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [AMP_W-1:0]      req_amplitude,
   input  logic [BIN_IDX_W-1:0]  req_bin_index,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEVEL_W-1:0]    rsp_averaged_level,
   output logic [BIN_IDX_W-1:0]  rsp_out_bin_index,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   lsfa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsfa_datapath #(
      .BIN_COUNT  (BIN_COUNT),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_amplitude      (req_amplitude),
      .req_bin_index      (req_bin_index),
      .req_frame_start    (req_frame_start),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_averaged_level (rsp_averaged_level),
      .rsp_out_bin_index  (rsp_out_bin_index)
   );

endmodule

// File: rtl/core/lsfa_checker.sv
// ----------------------------------------------------------------------------
// lsfa_checker: port level checks for the frame averager
// Tracks items in flight from the port handshakes and checks acceptance and
// stall behavior of the unit.
// ----------------------------------------------------------------------------
module lsfa_checker
   import lsfa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [LEVEL_W-1:0]    rsp_averaged_level,
   input logic [BIN_IDX_W-1:0]  rsp_out_bin_index
);

   logic [1:0] pend_ff, pend_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + 2'(req_fire) - 2'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_averaged_level)
                                  && $stable(rsp_out_bin_index))
      else $error("result changed while stalled");

   a_clear_blocks: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("item taken during store clearing");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second item taken while one is in work");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an accepted item");

   a_accept_depth: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> pend_ff == 2'd0 || pend_ff == 2'd1)
      else $error("too many items in flight");

endmodule

bind log_spectrum_frame_averager_unit lsfa_checker u_lsfa_checker (.*);
